FILE: hdl/kgr_pkg.sv
// ----------------------------------------------------------------------------
// kgr_pkg
// Shared types and constants for the k-group reversing stream block.
// ----------------------------------------------------------------------------
package kgr_pkg;

    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // read request towards the buffer and the output stage
    typedef struct packed {
        logic rd_en;
        logic run_end;
        logic seq_end;
    } t_rd_ctl;

endpackage

FILE: hdl/kgr_in_if.sv
// ----------------------------------------------------------------------------
// kgr_in_if
// Input channel: one sequence value per transfer, with the final flag.
// ----------------------------------------------------------------------------
interface kgr_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [kgr_pkg::VALUE_W-1:0]  item_value;
    logic                                final_item;

    modport source (output valid, output item_value, output final_item, input ready);
    modport sink   (input valid, input item_value, input final_item, output ready);

endinterface

FILE: hdl/kgr_out_if.sv
// ----------------------------------------------------------------------------
// kgr_out_if
// Output channel: one reordered value per transfer, with run and sequence marks.
// ----------------------------------------------------------------------------
interface kgr_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [kgr_pkg::VALUE_W-1:0]  out_value;
    logic                                run_end;
    logic                                sequence_end;

    modport source (output valid, output out_value, output run_end, output sequence_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_end, input sequence_end,
                    output ready);

endinterface

FILE: hdl/kgr_ram.sv
// ----------------------------------------------------------------------------
// kgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/kgr_ctrl.sv
// ----------------------------------------------------------------------------
// kgr_ctrl
// Fill counter, group size register and read sequencer for the group buffer.
// ----------------------------------------------------------------------------
module kgr_ctrl #(
    parameter int MAX_GROUP = 16,
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kgr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kgr_pkg::VALUE_W-1:0]   i_item_value,
    input  logic                          i_final_item,
    input  logic                          i_out_free,
    output logic                          o_we,
    output logic [IW-1:0]                 o_waddr,
    output logic [kgr_pkg::VALUE_W-1:0]   o_wdata,
    output logic [IW-1:0]                 o_raddr,
    output kgr_pkg::t_rd_ctl              o_rd_ctl
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > kgr_pkg::CFG_W) ? CW : kgr_pkg::CFG_W;

    kgr_pkg::t_state             r_state, n_state;
    logic [kgr_pkg::CFG_W-1:0]   r_group_size;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               r_left;
    logic [IW-1:0]               r_idx;
    logic                        r_rev;
    logic                        r_last;

    logic [KW-1:0] w_gs;
    logic [KW-1:0] w_k;
    logic          w_room;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_n_dec;
    logic          w_full;
    logic          w_acc;
    logic          w_emit;
    logic          w_rd;
    logic          w_last_rd;

    always_comb begin
        w_gs = KW'(r_group_size);
        priority if (w_gs == '0) begin
            w_k = KW'(1);
        end else if (w_gs > KW'(MAX_GROUP)) begin
            w_k = KW'(MAX_GROUP);
        end else begin
            w_k = w_gs;
        end
    end

    assign w_room    = (r_fill < CW'(MAX_GROUP));
    assign w_n       = w_room ? (r_fill + CW'(1)) : r_fill;
    assign w_n_dec   = w_n - CW'(1);
    assign w_full    = (KW'(w_n) >= w_k);
    assign w_acc     = i_valid && o_ready;
    assign w_emit    = w_acc && (w_full || i_final_item);
    assign w_rd      = (r_state == kgr_pkg::ST_EMIT) && i_out_free;
    assign w_last_rd = (r_left == CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kgr_pkg::ST_IDLE: begin
                if (w_emit) begin
                    n_state = kgr_pkg::ST_EMIT;
                end
            end
            kgr_pkg::ST_EMIT: begin
                if (w_rd && w_last_rd) begin
                    n_state = kgr_pkg::ST_IDLE;
                end
            end
            default: n_state = kgr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready          = 1'b0;
        o_rd_ctl.rd_en   = 1'b0;
        o_rd_ctl.run_end = w_last_rd;
        o_rd_ctl.seq_end = w_last_rd && r_last;
        unique case (r_state)
            kgr_pkg::ST_IDLE: o_ready        = 1'b1;
            kgr_pkg::ST_EMIT: o_rd_ctl.rd_en = i_out_free;
            default:          o_ready        = 1'b0;
        endcase
    end

    assign o_we    = w_acc && w_room;
    assign o_waddr = r_fill[IW-1:0];
    assign o_wdata = i_item_value;
    assign o_raddr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kgr_pkg::ST_IDLE;
            r_group_size <= kgr_pkg::GROUP_SIZE_RESET;
            r_fill       <= '0;
            r_left       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_group_size <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_fill <= '0;
                r_left <= w_n;
            end else if (w_acc) begin
                r_fill <= w_n;
            end else if (w_rd) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_rev  <= w_full;
            r_last <= i_final_item;
            r_idx  <= w_full ? w_n_dec[IW-1:0] : '0;
        end else if (w_rd) begin
            r_idx <= r_rev ? (r_idx - IW'(1)) : (r_idx + IW'(1));
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CW'(MAX_GROUP))
        else $error("fill count reached the buffer depth");

    a_no_read_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_rd_ctl.rd_en)
        else $error("buffer read while accepting input");

    a_run_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_ctl.rd_en && o_rd_ctl.run_end) |=> (r_state == kgr_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after run end");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_left != '0) && (r_fill == '0))
        else $error("emission started with empty run");
`endif

endmodule

FILE: hdl/k_group_reverse_stream.sv
// ----------------------------------------------------------------------------
// k_group_reverse_stream
// Buffers a stream of signed values and emits each full group in reverse.
// ----------------------------------------------------------------------------
// Values are written into a MAX_GROUP-deep buffer RAM as they arrive, one input
// transfer per cycle while no group is being emitted. When group_size values are
// held, or a final item arrives, the buffered values are read back one per cycle
// while the output register is free, through the RAM's registered read port
// (newest first for a full group, oldest first for a partial remainder) into the
// output register. An item that causes results holds the input until the last of
// them has been read from the buffer. group_size is written through i_cfg_we /
// i_cfg_wdata; zero acts as one and values above MAX_GROUP as MAX_GROUP.
// ----------------------------------------------------------------------------
module k_group_reverse_stream #(
    parameter int MAX_GROUP = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kgr_in_if.sink                     i_in,
    kgr_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [kgr_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic                           w_we;
    logic [IW-1:0]                  w_waddr;
    logic [kgr_pkg::VALUE_W-1:0]    w_wdata;
    logic [IW-1:0]                  w_raddr;
    logic [kgr_pkg::VALUE_W-1:0]    w_rdata;
    kgr_pkg::t_rd_ctl               w_rd_ctl;
    logic                           w_out_free;

    logic r_out_valid;
    logic r_run_end;
    logic r_seq_end;

    assign w_out_free = !r_out_valid || o_out.ready;

    kgr_ctrl #(
        .MAX_GROUP (MAX_GROUP),
        .IW        (IW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_item_value (i_in.item_value),
        .i_final_item (i_in.final_item),
        .i_out_free   (w_out_free),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr),
        .o_rd_ctl     (w_rd_ctl)
    );

    kgr_ram #(
        .WIDTH (kgr_pkg::VALUE_W),
        .DEPTH (MAX_GROUP),
        .AW    (IW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_ctl.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register: value sits in the RAM read register, flags here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rd_ctl.rd_en) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_ctl.rd_en) begin
            r_run_end <= w_rd_ctl.run_end;
            r_seq_end <= w_rd_ctl.seq_end;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_value    = $signed(w_rdata);
    assign o_out.run_end      = r_run_end;
    assign o_out.sequence_end = r_seq_end;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_ctl.rd_en |-> (!r_out_valid || o_out.ready))
        else $error("output register overwritten before transfer");

    a_seq_end_has_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seq_end) |-> r_run_end)
        else $error("sequence end without run end");
`endif

endmodule

FILE: tb/k_group_reverse_stream_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_group_reverse_stream_test
// Self-checking bench for the k-group reversing stream block. Sequences of
// signed values go in over the input channel; an in-bench predictor of the
// group buffer forms the reordered values and their run and sequence marks,
// and every output transfer is checked against them in order. The run covers
// directed corner cases, group sizes from zero up to beyond the buffer depth,
// and random sequences under several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module k_group_reverse_stream_test;

    localparam int MAX_GROUP   = 16;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RX_HOLD_CYC = 300;

    typedef struct packed {
        logic signed [kgr_pkg::VALUE_W-1:0] value;
        logic                               final_item;
    } t_seq_item;

    typedef struct packed {
        logic signed [kgr_pkg::VALUE_W-1:0] value;
        logic                               run_end;
        logic                               seq_end;
    } t_reordered;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [kgr_pkg::CFG_W-1:0] cfg_wdata;

    kgr_in_if  in_ch ();
    kgr_out_if out_ch ();

    k_group_reverse_stream #(
        .MAX_GROUP (MAX_GROUP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    t_seq_item                          pending_q[$];
    t_reordered                         reordered_q[$];
    logic signed [kgr_pkg::VALUE_W-1:0] group_buf_m [MAX_GROUP];
    int unsigned                        fill_m = 0;
    logic [kgr_pkg::CFG_W-1:0]          group_size_m;

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    bit          rx_hold;
    int          fault_count = 0;
    int          values_in   = 0;
    int          values_out  = 0;
    int          sequences;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // buffer model: store, then emit reversed when full or forwards on a short final
    task automatic predict_reorder(input t_seq_item it);
        int unsigned k;
        int unsigned n;
        bit          full;
        t_reordered  r;
        k = (group_size_m == 0) ? 1 :
            (group_size_m > MAX_GROUP) ? MAX_GROUP : group_size_m;
        if (fill_m < MAX_GROUP) begin
            group_buf_m[fill_m] = it.value;
            fill_m++;
        end
        n = fill_m;
        full = (n >= k);
        if (full || it.final_item) begin
            for (int i = 0; i < n; i++) begin
                r.value   = full ? group_buf_m[n-1-i] : group_buf_m[i];
                r.run_end = (i == n - 1);
                r.seq_end = (i == n - 1) && it.final_item;
                reordered_q.push_back(r);
            end
            fill_m = 0;
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                predict_reorder(pending_q.pop_front());
                values_in++;
                offer = 1'b0;
            end
            if (!offer && pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                offer = 1'b1;
                in_ch.item_value <= pending_q[0].value;
                in_ch.final_item <= pending_q[0].final_item;
            end
            in_ch.valid <= offer;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reordered want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                values_out++;
                if (reordered_q.size() == 0) begin
                    $error("unexpected transfer: out_value %0d", out_ch.out_value);
                    fault_count++;
                end else begin
                    want = reordered_q.pop_front();
                    if (out_ch.out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, out_ch.out_value);
                        fault_count++;
                    end
                    if (out_ch.run_end !== want.run_end) begin
                        $error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
                        fault_count++;
                    end
                    if (out_ch.sequence_end !== want.seq_end) begin
                        $error("sequence_end: expected %0b, got %0b",
                               want.seq_end, out_ch.sequence_end);
                        fault_count++;
                    end
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic signed [kgr_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_value(input logic signed [kgr_pkg::VALUE_W-1:0] v, input logic fin);
        t_seq_item it;
        it.value      = v;
        it.final_item = fin;
        pending_q.push_back(it);
        if (fin) sequences++;
    endtask

    // well-formed sequence; now and then a broken one with random final flags
    task automatic push_sequence(input int len);
        bit broken;
        broken = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++)
            push_value(pick_value(), broken ? 1'($urandom_range(1)) : (i == len - 1));
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_ch.valid || reordered_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_group_size(input logic [kgr_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        group_size_m = v;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned tx, input int unsigned rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    task automatic random_phase(input int n_items, input bit pause_mid);
        int unsigned k;
        int          count;
        int          len;
        k = (group_size_m == 0) ? 1 :
            (group_size_m > MAX_GROUP) ? MAX_GROUP : group_size_m;
        count = 0;
        while (count < n_items) begin
            len = $urandom_range(1, 2 * k + 2);
            if (len > n_items - count + 2) len = n_items - count + 2;
            push_sequence(len);
            count += len;
            // sender holds back until every result so far is out
            if (pause_mid && count >= n_items / 2 && count - len < n_items / 2) begin
                while (pending_q.size() != 0 || reordered_q.size() != 0)
                    @(negedge i_clk);
            end
        end
        wait_idle();
    endtask

    initial begin
        bit leftover;
        leftover         = 1'b0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        group_size_m     = kgr_pkg::GROUP_SIZE_RESET;
        rx_hold          = 1'b0;
        sequences        = 0;
        set_idling(0, 0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset size: pairs reversed, odd tail forwards
        push_value(32'h7fffffff, 1'b0);
        push_value(32'h80000000, 1'b0);
        push_value(32'h0, 1'b0);
        push_value(32'hffffffff, 1'b0);
        push_value(32'sd5, 1'b1);
        wait_idle();
        // zero acts as one
        write_group_size(5'd0);
        push_value(32'hffffffff, 1'b0);
        push_value(32'sd1, 1'b1);
        wait_idle();
        // above depth saturates; short final emits in order
        write_group_size(5'd31);
        push_value(32'sh5555aaaa, 1'b0);
        push_value(32'shaaaa5555, 1'b0);
        push_value(32'sd7, 1'b1);
        wait_idle();
        // final item closes a full group
        write_group_size(5'd3);
        push_value(32'sd10, 1'b0);
        push_value(32'sd20, 1'b0);
        push_value(32'sd30, 1'b1);
        wait_idle();
        // size lowered with items still buffered
        write_group_size(5'd8);
        push_value(32'sd100, 1'b0);
        push_value(32'sd200, 1'b0);
        push_value(32'sd300, 1'b0);
        wait_idle();
        write_group_size(5'd2);
        push_value(32'sd400, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(51, 0);
                2: set_idling(0, 51);
                default: set_idling(33, 33);
            endcase
            case (p)
                0: write_group_size(5'd16);
                1: write_group_size(5'd1);
                2: write_group_size(5'd0);
                3: write_group_size(5'd31);
                4: write_group_size(5'($urandom_range(2, 15)));
                5: write_group_size(5'd2);
                6: write_group_size(5'd16);
                default: write_group_size(5'($urandom_range(31)));
            endcase
            random_phase(16, p == 0);
        end

        // receiver holds off long enough for the block to back up its input
        set_idling(0, 0);
        write_group_size(5'd16);
        push_sequence(20);
        push_sequence(10);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYC) @(negedge i_clk);
        rx_hold = 1'b0;
        wait_idle();

        if (reordered_q.size() != 0) begin
            $error("%0d expected results never arrived", reordered_q.size());
            leftover = 1'b1;
        end
        $display("covered %0d input and %0d output transfers over %0d sequences,",
                 values_in, values_out, sequences);
        $display("group sizes 0 to 31, a mid-group size change and four stall patterns");
        if (fault_count == 0 && !leftover) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
